[sv/ggf_pkg.sv]
// Shared constants, types and register codes of the guidance gradient field unit
`timescale 1ns / 1ps
`default_nettype none
package ggf_pkg;

  localparam int LINE_MAX    = 1024;
  localparam int SAMPLE_BITS = 8;
  localparam int RING_BITS   = $clog2(2 * LINE_MAX + 2);
  localparam int COL_BITS    = $clog2(LINE_MAX);
  localparam int EW_BITS     = COL_BITS + 1;
  localparam int LAG_BITS    = $clog2(LINE_MAX + 2);
  localparam int WIDTH_BITS  = 11;
  localparam int HEIGHT_BITS = 16;
  localparam int WEIGHT_BITS = 9;
  localparam int GRAD_BITS   = 17;
  localparam int WORD_BITS   = 2 * SAMPLE_BITS;
  localparam int DIFF_BITS   = SAMPLE_BITS + 1;
  localparam int FRAC_BITS   = 8;
  localparam int WEIGHT_ONE  = 256;
  localparam int PADDR_BITS  = 4;
  localparam int PDATA_BITS  = 32;

  localparam int WIDTH_RESET  = 1024;
  localparam int HEIGHT_RESET = 1;

  localparam logic FUNC_FLUSH = 1'b1;

  typedef enum logic [1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_MIXED_MODE   = 2'd2,
    REG_FG_WEIGHT    = 2'd3
  } reg_idx_e;

  typedef logic [WORD_BITS-1:0] word_t;

  typedef struct packed {
    logic [EW_BITS-1:0]     width;
    logic [HEIGHT_BITS-1:0] height;
    logic                   mixed;
    logic [WEIGHT_BITS-1:0] weight;
  } cfg_t;

  typedef struct packed {
    logic                 we;
    logic [RING_BITS-1:0] waddr;
    word_t                wdata;
    logic                 re;
    logic [RING_BITS-1:0] left;
    logic [RING_BITS-1:0] right;
    logic [RING_BITS-1:0] up;
    logic [RING_BITS-1:0] down;
  } mem_req_t;

  typedef struct packed {
    logic emit;
    logic eof;
  } tag_t;

  typedef struct packed {
    word_t left;
    word_t right;
    word_t up;
    word_t down;
  } nbr_t;

endpackage
`default_nettype wire

[sv/ggf_in_if.sv]
// Sample pair channel: valid/ready handshake with function code and samples
`timescale 1ns / 1ps
`default_nettype none
interface ggf_in_if;
  logic                            valid;
  logic                            ready;
  logic                            func;
  logic [ggf_pkg::SAMPLE_BITS-1:0] fg_sample;
  logic [ggf_pkg::SAMPLE_BITS-1:0] bg_sample;

  modport source (output valid, output func, output fg_sample, output bg_sample, input ready);
  modport sink (input valid, input func, input fg_sample, input bg_sample, output ready);
endinterface
`default_nettype wire

[sv/ggf_out_if.sv]
// Gradient result channel: valid/ready handshake with gradient payload
`timescale 1ns / 1ps
`default_nettype none
interface ggf_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [ggf_pkg::GRAD_BITS-1:0] grad_x;
  logic signed [ggf_pkg::GRAD_BITS-1:0] grad_y;
  logic                                 took_foreground;
  logic                                 end_of_frame;

  modport source (output valid, output grad_x, output grad_y, output took_foreground,
                  output end_of_frame, input ready);
  modport sink (input valid, input grad_x, input grad_y, input took_foreground,
                input end_of_frame, output ready);
endinterface
`default_nettype wire

[sv/ggf_ram.sv]
// Generic RAM with one write port and two registered read ports
`timescale 1ns / 1ps
`default_nettype none
module ggf_ram #(
  parameter int ADDR_W = 12,
  parameter int DATA_W = 16
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [DATA_W-1:0] wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_a_i,
  input  wire logic [ADDR_W-1:0] raddr_b_i,
  output logic      [DATA_W-1:0] rdata_a_o,
  output logic      [DATA_W-1:0] rdata_b_o
);

  logic [DATA_W-1:0] mem_q [2**ADDR_W];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_o <= mem_q[raddr_a_i];
      rdata_b_o <= mem_q[raddr_b_i];
    end
  end

endmodule
`default_nettype wire

[sv/ggf_cfg.sv]
// APB register file holding frame geometry, mode and weight
`timescale 1ns / 1ps
`default_nettype none
module ggf_cfg (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [ggf_pkg::PADDR_BITS-1:0]   paddr,
  input  wire logic [ggf_pkg::PDATA_BITS-1:0]   pwdata,
  output logic      [ggf_pkg::PDATA_BITS-1:0]   prdata,
  output logic                                  pready,
  output ggf_pkg::cfg_t                         cfg_o,
  output logic                                  restart_o
);

  logic [ggf_pkg::WIDTH_BITS-1:0]  width_q, width_d;
  logic [ggf_pkg::HEIGHT_BITS-1:0] height_q, height_d;
  logic                            mixed_q, mixed_d;
  logic [ggf_pkg::WEIGHT_BITS-1:0] weight_q, weight_d;
  logic                            wr;
  ggf_pkg::reg_idx_e               idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = ggf_pkg::reg_idx_e'(paddr[ggf_pkg::PADDR_BITS-1:2]);

  always_comb begin
    width_d   = width_q;
    height_d  = height_q;
    mixed_d   = mixed_q;
    weight_d  = weight_q;
    restart_o = 1'b0;
    if (wr) begin
      case (idx)
        ggf_pkg::REG_FRAME_WIDTH: begin
          width_d   = pwdata[ggf_pkg::WIDTH_BITS-1:0];
          restart_o = 1'b1;
        end
        ggf_pkg::REG_FRAME_HEIGHT: begin
          height_d  = pwdata[ggf_pkg::HEIGHT_BITS-1:0];
          restart_o = 1'b1;
        end
        ggf_pkg::REG_MIXED_MODE: begin
          mixed_d = pwdata[0];
        end
        ggf_pkg::REG_FG_WEIGHT: begin
          weight_d = pwdata[ggf_pkg::WEIGHT_BITS-1:0];
        end
        default: begin
          restart_o = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= ggf_pkg::WIDTH_BITS'(ggf_pkg::WIDTH_RESET);
      height_q <= ggf_pkg::HEIGHT_BITS'(ggf_pkg::HEIGHT_RESET);
      mixed_q  <= 1'b0;
      weight_q <= ggf_pkg::WEIGHT_BITS'(ggf_pkg::WEIGHT_ONE);
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
      mixed_q  <= mixed_d;
      weight_q <= weight_d;
    end
  end

  always_comb begin
    case (idx)
      ggf_pkg::REG_FRAME_WIDTH:  prdata = ggf_pkg::PDATA_BITS'(width_q);
      ggf_pkg::REG_FRAME_HEIGHT: prdata = ggf_pkg::PDATA_BITS'(height_q);
      ggf_pkg::REG_MIXED_MODE:   prdata = ggf_pkg::PDATA_BITS'(mixed_q);
      ggf_pkg::REG_FG_WEIGHT:    prdata = ggf_pkg::PDATA_BITS'(weight_q);
      default:                   prdata = '0;
    endcase
  end

  // clamp geometry and weight to their usable ranges
  always_comb begin
    if (width_q == '0) begin
      cfg_o.width = ggf_pkg::EW_BITS'(1);
    end else if (32'(width_q) > ggf_pkg::LINE_MAX) begin
      cfg_o.width = ggf_pkg::EW_BITS'(ggf_pkg::LINE_MAX);
    end else begin
      cfg_o.width = ggf_pkg::EW_BITS'(width_q);
    end
    cfg_o.height = (height_q == '0) ? ggf_pkg::HEIGHT_BITS'(1) : height_q;
    cfg_o.mixed  = mixed_q;
    if (32'(weight_q) > ggf_pkg::WEIGHT_ONE) begin
      cfg_o.weight = ggf_pkg::WEIGHT_BITS'(ggf_pkg::WEIGHT_ONE);
    end else begin
      cfg_o.weight = weight_q;
    end
  end

endmodule
`default_nettype wire

[sv/ggf_ctrl.sv]
// Position counters, line store addressing and emit decision
`timescale 1ns / 1ps
`default_nettype none
module ggf_ctrl (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            accept_i,
  input  wire logic                            func_i,
  input  wire logic [ggf_pkg::SAMPLE_BITS-1:0] fg_sample_i,
  input  wire logic [ggf_pkg::SAMPLE_BITS-1:0] bg_sample_i,
  input  wire ggf_pkg::cfg_t                   cfg_i,
  input  wire logic                            restart_i,
  output ggf_pkg::mem_req_t                    mem_req_o,
  output ggf_pkg::tag_t                        tag_o
);

  logic [ggf_pkg::COL_BITS-1:0]    col_q, col_d;
  logic [ggf_pkg::HEIGHT_BITS-1:0] row_q, row_d;
  logic [ggf_pkg::RING_BITS-1:0]   nslot_q, nslot_d;
  logic [ggf_pkg::COL_BITS-1:0]    ecol_q, ecol_d;
  logic [ggf_pkg::HEIGHT_BITS-1:0] erow_q, erow_d;
  logic [ggf_pkg::RING_BITS-1:0]   eslot_q, eslot_d;
  logic [ggf_pkg::LAG_BITS-1:0]    lag_q, lag_d;

  logic                            in_done, is_sample, emit, eof;
  logic                            col_last, ecol_last, erow_first, erow_last, ecol_first;
  logic [ggf_pkg::EW_BITS-1:0]     w_m1;
  logic [ggf_pkg::RING_BITS-1:0]   w_ring;

  assign w_m1       = cfg_i.width - ggf_pkg::EW_BITS'(1);
  assign w_ring     = ggf_pkg::RING_BITS'(cfg_i.width);
  assign in_done    = (row_q == cfg_i.height);
  assign is_sample  = (func_i != ggf_pkg::FUNC_FLUSH) && !in_done;
  assign col_last   = ({1'b0, col_q} == w_m1);
  assign ecol_first = (ecol_q == '0);
  assign ecol_last  = ({1'b0, ecol_q} == w_m1);
  assign erow_first = (erow_q == '0);
  assign erow_last  = (erow_q == cfg_i.height - ggf_pkg::HEIGHT_BITS'(1));
  assign eof        = ecol_last && erow_last;
  assign emit       = is_sample ? (32'(lag_q) > 32'(cfg_i.width)) : in_done;

  always_comb begin
    mem_req_o.we    = accept_i && is_sample;
    mem_req_o.waddr = nslot_q;
    mem_req_o.wdata = {fg_sample_i, bg_sample_i};
    mem_req_o.re    = accept_i;
    mem_req_o.left  = ecol_first ? eslot_q : eslot_q - ggf_pkg::RING_BITS'(1);
    mem_req_o.right = ecol_last  ? eslot_q : eslot_q + ggf_pkg::RING_BITS'(1);
    mem_req_o.up    = erow_first ? eslot_q : eslot_q - w_ring;
    mem_req_o.down  = erow_last  ? eslot_q : eslot_q + w_ring;
    tag_o.emit      = emit;
    tag_o.eof       = eof;
  end

  always_comb begin
    col_d   = col_q;
    row_d   = row_q;
    nslot_d = nslot_q;
    ecol_d  = ecol_q;
    erow_d  = erow_q;
    eslot_d = eslot_q;
    lag_d   = lag_q;
    if (restart_i) begin
      col_d   = '0;
      row_d   = '0;
      nslot_d = '0;
      ecol_d  = '0;
      erow_d  = '0;
      eslot_d = '0;
      lag_d   = '0;
    end else if (accept_i) begin
      if (is_sample) begin
        nslot_d = nslot_q + ggf_pkg::RING_BITS'(1);
        if (col_last) begin
          col_d = '0;
          row_d = row_q + ggf_pkg::HEIGHT_BITS'(1);
        end else begin
          col_d = col_q + ggf_pkg::COL_BITS'(1);
        end
      end
      if (emit && eof) begin
        col_d   = '0;
        row_d   = '0;
        nslot_d = '0;
        ecol_d  = '0;
        erow_d  = '0;
        eslot_d = '0;
        lag_d   = '0;
      end else begin
        if (emit) begin
          eslot_d = eslot_q + ggf_pkg::RING_BITS'(1);
          if (ecol_last) begin
            ecol_d = '0;
            erow_d = erow_q + ggf_pkg::HEIGHT_BITS'(1);
          end else begin
            ecol_d = ecol_q + ggf_pkg::COL_BITS'(1);
          end
        end
        if (is_sample && !emit) begin
          lag_d = lag_q + ggf_pkg::LAG_BITS'(1);
        end else if (!is_sample && emit) begin
          lag_d = lag_q - ggf_pkg::LAG_BITS'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      nslot_q <= '0;
      ecol_q  <= '0;
      erow_q  <= '0;
      eslot_q <= '0;
      lag_q   <= '0;
    end else begin
      col_q   <= col_d;
      row_q   <= row_d;
      nslot_q <= nslot_d;
      ecol_q  <= ecol_d;
      erow_q  <= erow_d;
      eslot_q <= eslot_d;
      lag_q   <= lag_d;
    end
  end

endmodule
`default_nettype wire

[sv/ggf_grad.sv]
// Gradient arithmetic, blend or pick, and the result register
`timescale 1ns / 1ps
`default_nettype none
module ggf_grad (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire ggf_pkg::cfg_t cfg_i,
  input  wire logic          accept_i,
  input  wire ggf_pkg::tag_t tag_i,
  input  wire ggf_pkg::nbr_t nbr_i,
  output logic               ready_o,
  ggf_out_if.source          grad_o
);

  localparam int SQ_BITS   = 2 * ggf_pkg::DIFF_BITS;
  localparam int MAG_BITS  = SQ_BITS + 1;
  localparam int PROD_BITS = ggf_pkg::WEIGHT_BITS + 1 + ggf_pkg::DIFF_BITS;
  localparam int SUM_BITS  = PROD_BITS + 1;
  localparam int SCL_BITS  = ggf_pkg::DIFF_BITS + ggf_pkg::FRAC_BITS;
  localparam int SB        = ggf_pkg::SAMPLE_BITS;
  localparam int WB        = ggf_pkg::WORD_BITS;

  logic                                  s1_v_q, s1_v_d, s1_eof_q, s1_eof_d;
  logic                                  out_v_q, out_v_d;
  logic signed [ggf_pkg::GRAD_BITS-1:0]  gx_q, gx_d, gy_q, gy_d;
  logic                                  took_q, took_d, eof_q, eof_d;
  logic                                  out_free, s1_move;

  logic signed [ggf_pkg::DIFF_BITS-1:0]  fx, fy, bx, by;
  logic signed [SQ_BITS-1:0]             fx2, fy2, bx2, by2;
  logic signed [MAG_BITS-1:0]            fmag, bmag;
  logic signed [ggf_pkg::WEIGHT_BITS:0]  wf, wb;
  logic signed [PROD_BITS-1:0]           pfx, pfy, pbx, pby;
  logic signed [SUM_BITS-1:0]            sx, sy;
  logic signed [SCL_BITS-1:0]            fxs, fys, bxs, bys;

  assign fx = $signed({1'b0, nbr_i.right[WB-1:SB]}) - $signed({1'b0, nbr_i.left[WB-1:SB]});
  assign fy = $signed({1'b0, nbr_i.down[WB-1:SB]})  - $signed({1'b0, nbr_i.up[WB-1:SB]});
  assign bx = $signed({1'b0, nbr_i.right[SB-1:0]})  - $signed({1'b0, nbr_i.left[SB-1:0]});
  assign by = $signed({1'b0, nbr_i.down[SB-1:0]})   - $signed({1'b0, nbr_i.up[SB-1:0]});

  assign fx2  = fx * fx;
  assign fy2  = fy * fy;
  assign bx2  = bx * bx;
  assign by2  = by * by;
  assign fmag = MAG_BITS'(fx2) + MAG_BITS'(fy2);
  assign bmag = MAG_BITS'(bx2) + MAG_BITS'(by2);

  assign wf  = $signed({1'b0, cfg_i.weight});
  assign wb  = $signed({1'b0, ggf_pkg::WEIGHT_BITS'(ggf_pkg::WEIGHT_ONE) - cfg_i.weight});
  assign pfx = wf * fx;
  assign pfy = wf * fy;
  assign pbx = wb * bx;
  assign pby = wb * by;
  assign sx  = SUM_BITS'(pfx) + SUM_BITS'(pbx);
  assign sy  = SUM_BITS'(pfy) + SUM_BITS'(pby);

  assign fxs = {fx, {ggf_pkg::FRAC_BITS{1'b0}}};
  assign fys = {fy, {ggf_pkg::FRAC_BITS{1'b0}}};
  assign bxs = {bx, {ggf_pkg::FRAC_BITS{1'b0}}};
  assign bys = {by, {ggf_pkg::FRAC_BITS{1'b0}}};

  assign out_free = !out_v_q || grad_o.ready;
  assign s1_move  = s1_v_q && out_free;
  assign ready_o  = !s1_v_q || out_free;

  always_comb begin
    s1_v_d   = s1_v_q;
    s1_eof_d = s1_eof_q;
    if (accept_i) begin
      s1_v_d   = tag_i.emit;
      s1_eof_d = tag_i.eof;
    end else if (s1_move) begin
      s1_v_d = 1'b0;
    end
  end

  always_comb begin
    out_v_d = out_v_q;
    gx_d    = gx_q;
    gy_d    = gy_q;
    took_d  = took_q;
    eof_d   = eof_q;
    if (s1_move) begin
      out_v_d = 1'b1;
      eof_d   = s1_eof_q;
      if (cfg_i.mixed) begin
        took_d = (fmag > bmag);
        gx_d   = (fmag > bmag) ? fxs[ggf_pkg::GRAD_BITS-1:0] : bxs[ggf_pkg::GRAD_BITS-1:0];
        gy_d   = (fmag > bmag) ? fys[ggf_pkg::GRAD_BITS-1:0] : bys[ggf_pkg::GRAD_BITS-1:0];
      end else begin
        took_d = 1'b0;
        gx_d   = sx[ggf_pkg::GRAD_BITS-1:0];
        gy_d   = sy[ggf_pkg::GRAD_BITS-1:0];
      end
    end else if (grad_o.ready) begin
      out_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q   <= 1'b0;
      s1_eof_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      s1_v_q   <= s1_v_d;
      s1_eof_q <= s1_eof_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    gx_q   <= gx_d;
    gy_q   <= gy_d;
    took_q <= took_d;
    eof_q  <= eof_d;
  end

  assign grad_o.valid           = out_v_q;
  assign grad_o.grad_x          = gx_q;
  assign grad_o.grad_y          = gy_q;
  assign grad_o.took_foreground = took_q;
  assign grad_o.end_of_frame    = eof_q;

endmodule
`default_nettype wire

[sv/guidance_gradient_field_unit.sv]
// Top level of the guidance gradient field unit
//
//   channel  direction  handshake          payload
//   pix_i    in         valid/ready        func, fg_sample, bg_sample
//   grad_o   out        valid/ready        grad_x, grad_y, took_foreground, end_of_frame
//   apb      in         psel/penable       paddr, pwdata, prdata (pready tied high)
//
// One item per clock while input ready is high. The line store is read at the accepting
// edge and the gradient arithmetic runs in the next cycle, registered once the output is free.
// Reset clears counters and valid flags; line store contents are not cleared.
// A stalled result holds in the output register while one more item is taken into
// the read stage; input ready drops only when both are full.
`timescale 1ns / 1ps
`default_nettype none
module guidance_gradient_field_unit (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [ggf_pkg::PADDR_BITS-1:0] paddr,
  input  wire logic [ggf_pkg::PDATA_BITS-1:0] pwdata,
  output logic      [ggf_pkg::PDATA_BITS-1:0] prdata,
  output logic                                pready,
  ggf_in_if.sink                              pix_i,
  ggf_out_if.source                           grad_o
);

  ggf_pkg::cfg_t     cfg;
  ggf_pkg::mem_req_t mem_req;
  ggf_pkg::tag_t     tag;
  ggf_pkg::nbr_t     nbr;
  logic              restart;
  logic              accept;
  logic              ready;

  assign pix_i.ready = ready;
  assign accept      = pix_i.valid && ready;

  ggf_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .cfg_o     (cfg),
    .restart_o (restart)
  );

  ggf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .func_i      (pix_i.func),
    .fg_sample_i (pix_i.fg_sample),
    .bg_sample_i (pix_i.bg_sample),
    .cfg_i       (cfg),
    .restart_i   (restart),
    .mem_req_o   (mem_req),
    .tag_o       (tag)
  );

  ggf_ram #(
    .ADDR_W (ggf_pkg::RING_BITS),
    .DATA_W (ggf_pkg::WORD_BITS)
  ) u_ram_row (
    .clk_i     (clk_i),
    .we_i      (mem_req.we),
    .waddr_i   (mem_req.waddr),
    .wdata_i   (mem_req.wdata),
    .re_i      (mem_req.re),
    .raddr_a_i (mem_req.left),
    .raddr_b_i (mem_req.right),
    .rdata_a_o (nbr.left),
    .rdata_b_o (nbr.right)
  );

  ggf_ram #(
    .ADDR_W (ggf_pkg::RING_BITS),
    .DATA_W (ggf_pkg::WORD_BITS)
  ) u_ram_col (
    .clk_i     (clk_i),
    .we_i      (mem_req.we),
    .waddr_i   (mem_req.waddr),
    .wdata_i   (mem_req.wdata),
    .re_i      (mem_req.re),
    .raddr_a_i (mem_req.up),
    .raddr_b_i (mem_req.down),
    .rdata_a_o (nbr.up),
    .rdata_b_o (nbr.down)
  );

  ggf_grad u_grad (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .accept_i (accept),
    .tag_i    (tag),
    .nbr_i    (nbr),
    .ready_o  (ready),
    .grad_o   (grad_o)
  );

endmodule
`default_nettype wire

[dv/tb_top.sv]
// Self-checking testbench for the guidance gradient field unit: predicted gradients vs stream
`timescale 1ns / 1ps
module tb_top;
  import ggf_pkg::*;

  localparam int          RING_DEPTH     = 2 * LINE_MAX + 2;
  localparam int          RING_ADDR_BITS = $clog2(RING_DEPTH);
  localparam int          DRAIN_CYCLES   = 8;
  localparam int          LONG_HOLD      = 300;
  localparam int          RAND_ITEMS     = 290;
  localparam int unsigned CYCLE_LIMIT    = 200000;
  localparam logic        FUNC_PIXEL     = ~FUNC_FLUSH;

  typedef struct packed {
    logic                   func;
    logic [SAMPLE_BITS-1:0] fg_sample;
    logic [SAMPLE_BITS-1:0] bg_sample;
  } pix_item_t;

  typedef struct packed {
    logic signed [GRAD_BITS-1:0] grad_x;
    logic signed [GRAD_BITS-1:0] grad_y;
    logic                        took_foreground;
    logic                        end_of_frame;
  } grad_res_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [PADDR_BITS-1:0] paddr;
  logic [PDATA_BITS-1:0] pwdata;
  wire  [PDATA_BITS-1:0] prdata;
  wire                   pready;

  ggf_in_if  pix_if ();
  ggf_out_if grad_if ();

  guidance_gradient_field_unit u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .pix_i   (pix_if),
    .grad_o  (grad_if)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  pix_item_t   pix_q[$];
  grad_res_t   grad_exp_q[$];
  int          err_cnt;
  int unsigned cycle_cnt;
  bit          in_fire;
  bit          idle_on;
  bit          hold_req;
  int          in_gap;
  int          out_stall;

  logic [SAMPLE_BITS-1:0] fg_ring [RING_DEPTH];
  logic [SAMPLE_BITS-1:0] bg_ring [RING_DEPTH];
  int unsigned            col_cnt;
  int unsigned            row_cnt;
  int unsigned            emit_ptr;
  logic [WIDTH_BITS-1:0]  cfg_width;
  logic [HEIGHT_BITS-1:0] cfg_height;
  logic                   cfg_mixed;
  logic [WEIGHT_BITS-1:0] cfg_weight;

  function automatic int unsigned active_width();
    if (cfg_width == 0) return 1;
    if (cfg_width > LINE_MAX) return LINE_MAX;
    return 32'(cfg_width);
  endfunction

  function automatic int unsigned active_height();
    return (cfg_height == 0) ? 1 : 32'(cfg_height);
  endfunction

  function automatic logic [RING_ADDR_BITS-1:0] ring_slot(int unsigned r, int unsigned c,
                                                          int unsigned w);
    return RING_ADDR_BITS'((r * w + c) % RING_DEPTH);
  endfunction

  function automatic void clear_position();
    col_cnt  = 0;
    row_cnt  = 0;
    emit_ptr = 0;
  endfunction

  function automatic grad_res_t next_gradient(int unsigned w, int unsigned h);
    int unsigned r, c, cl, cr, ru, rd;
    int          fx, fy, bx, by, gx, gy, wf;
    grad_res_t   res;
    r  = emit_ptr / w;
    c  = emit_ptr % w;
    cl = (c != 0) ? c - 1 : 0;
    cr = (c + 1 < w) ? c + 1 : w - 1;
    ru = (r != 0) ? r - 1 : 0;
    rd = (r + 1 < h) ? r + 1 : h - 1;
    fx = int'(fg_ring[ring_slot(r, cr, w)]) - int'(fg_ring[ring_slot(r, cl, w)]);
    fy = int'(fg_ring[ring_slot(rd, c, w)]) - int'(fg_ring[ring_slot(ru, c, w)]);
    bx = int'(bg_ring[ring_slot(r, cr, w)]) - int'(bg_ring[ring_slot(r, cl, w)]);
    by = int'(bg_ring[ring_slot(rd, c, w)]) - int'(bg_ring[ring_slot(ru, c, w)]);
    res.took_foreground = 1'b0;
    if (cfg_mixed) begin
      if (fx * fx + fy * fy > bx * bx + by * by) begin
        gx = fx * WEIGHT_ONE;
        gy = fy * WEIGHT_ONE;
        res.took_foreground = 1'b1;
      end else begin
        gx = bx * WEIGHT_ONE;
        gy = by * WEIGHT_ONE;
      end
    end else begin
      wf = (cfg_weight > WEIGHT_ONE) ? WEIGHT_ONE : int'(cfg_weight);
      gx = wf * fx + (WEIGHT_ONE - wf) * bx;
      gy = wf * fy + (WEIGHT_ONE - wf) * by;
    end
    res.grad_x = gx[GRAD_BITS-1:0];
    res.grad_y = gy[GRAD_BITS-1:0];
    emit_ptr++;
    res.end_of_frame = (emit_ptr == w * h);
    if (res.end_of_frame) clear_position();
    return res;
  endfunction

  function automatic void predict_gradient(pix_item_t it);
    int unsigned w, h, total, n;
    w     = active_width();
    h     = active_height();
    total = w * h;
    n     = row_cnt * w + col_cnt;
    if (it.func != FUNC_FLUSH && n < total) begin
      fg_ring[ring_slot(row_cnt, col_cnt, w)] = it.fg_sample;
      bg_ring[ring_slot(row_cnt, col_cnt, w)] = it.bg_sample;
      col_cnt++;
      if (col_cnt >= w) begin
        col_cnt = 0;
        row_cnt++;
      end
      n++;
      if (n - emit_ptr > w + 1) grad_exp_q.push_back(next_gradient(w, h));
    end else if (n == total && emit_ptr < total) begin
      grad_exp_q.push_back(next_gradient(w, h));
    end
  endfunction

  function automatic void push_pixel(logic [SAMPLE_BITS-1:0] fg, logic [SAMPLE_BITS-1:0] bg);
    pix_q.push_back('{func: FUNC_PIXEL, fg_sample: fg, bg_sample: bg});
  endfunction

  function automatic void push_flush();
    pix_q.push_back('{func: FUNC_FLUSH, fg_sample: SAMPLE_BITS'($urandom_range(0, 255)),
                      bg_sample: SAMPLE_BITS'($urandom_range(0, 255))});
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] pick_sample(int style);
    case (style)
      0:       return SAMPLE_BITS'($urandom_range(0, 255));
      1:       return $urandom_range(0, 1) ? 8'd255 : 8'd0;
      default: return 8'd128 + SAMPLE_BITS'($urandom_range(0, 1));
    endcase
  endfunction

  task automatic write_reg(reg_idx_e idx, logic [PDATA_BITS-1:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      REG_FRAME_WIDTH: begin
        cfg_width = val[WIDTH_BITS-1:0];
        clear_position();
      end
      REG_FRAME_HEIGHT: begin
        cfg_height = val[HEIGHT_BITS-1:0];
        clear_position();
      end
      REG_MIXED_MODE: cfg_mixed  = val[0];
      REG_FG_WEIGHT:  cfg_weight = val[WEIGHT_BITS-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic configure(logic [WIDTH_BITS-1:0] w, logic [HEIGHT_BITS-1:0] h, logic mixed,
                           logic [WEIGHT_BITS-1:0] weight);
    write_reg(REG_FRAME_WIDTH, PDATA_BITS'(w));
    write_reg(REG_FRAME_HEIGHT, PDATA_BITS'(h));
    write_reg(REG_MIXED_MODE, PDATA_BITS'(mixed));
    write_reg(REG_FG_WEIGHT, PDATA_BITS'(weight));
  endtask

  task automatic settle();
    while (pix_q.size() != 0 || pix_if.valid || grad_exp_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic queue_frame(int unsigned w_reg, int unsigned h_reg, inout int count);
    int unsigned w, h, cut;
    int          style;
    w     = (w_reg == 0) ? 1 : ((w_reg > LINE_MAX) ? LINE_MAX : w_reg);
    h     = (h_reg == 0) ? 1 : h_reg;
    style = $urandom_range(0, 2);
    cut   = ($urandom_range(0, 5) == 0) ? $urandom_range(0, w * h - 1) : w * h;
    for (int unsigned i = 0; i < cut; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        push_flush();
        count++;
      end
      push_pixel(pick_sample(style), pick_sample(style));
      count++;
    end
    if (cut == w * h) begin
      repeat (w + 1) begin
        if ($urandom_range(0, 3) == 0) begin
          push_pixel(SAMPLE_BITS'($urandom_range(0, 255)), SAMPLE_BITS'($urandom_range(0, 255)));
        end else begin
          push_flush();
        end
        count++;
      end
      repeat ($urandom_range(0, 2)) begin
        push_flush();
        count++;
      end
    end
  endtask

  // driver: offer the next item once the current one has transferred
  always @(negedge clk_i) begin
    pix_item_t it;
    if (rst_ni && (!pix_if.valid || in_fire)) begin
      if (in_gap == 0 && idle_on && $urandom_range(0, 5) == 0) in_gap = $urandom_range(1, 5);
      if (in_gap > 0) begin
        in_gap--;
        pix_if.valid <= 1'b0;
      end else if (pix_q.size() != 0) begin
        it = pix_q.pop_front();
        pix_if.valid     <= 1'b1;
        pix_if.func      <= it.func;
        pix_if.fg_sample <= it.fg_sample;
        pix_if.bg_sample <= it.bg_sample;
      end else begin
        pix_if.valid <= 1'b0;
      end
    end
    in_fire = 1'b0;
  end

  // receiver: random back-pressure, one long hold on request
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_req) begin
        out_stall = LONG_HOLD;
        hold_req  = 1'b0;
      end else if (out_stall == 0 && idle_on && $urandom_range(0, 5) == 0) begin
        out_stall = $urandom_range(1, 5);
      end
      if (out_stall > 0) begin
        out_stall--;
        grad_if.ready <= 1'b0;
      end else begin
        grad_if.ready <= 1'b1;
      end
    end
  end

  // monitor: predict on input transfer, compare on output transfer
  always @(posedge clk_i) begin
    grad_res_t exp_res;
    if (rst_ni) begin
      if (pix_if.valid && pix_if.ready) begin
        in_fire = 1'b1;
        predict_gradient('{func: pix_if.func, fg_sample: pix_if.fg_sample,
                           bg_sample: pix_if.bg_sample});
      end
      if (grad_if.valid && grad_if.ready) begin
        if (grad_exp_q.size() == 0) begin
          $error("unexpected gradient result: grad_x %0d grad_y %0d",
                 grad_if.grad_x, grad_if.grad_y);
          err_cnt++;
        end else begin
          exp_res = grad_exp_q.pop_front();
          if (grad_if.grad_x !== exp_res.grad_x) begin
            $error("grad_x: expected %0d, got %0d", exp_res.grad_x, grad_if.grad_x);
            err_cnt++;
          end
          if (grad_if.grad_y !== exp_res.grad_y) begin
            $error("grad_y: expected %0d, got %0d", exp_res.grad_y, grad_if.grad_y);
            err_cnt++;
          end
          if (grad_if.took_foreground !== exp_res.took_foreground) begin
            $error("took_foreground: expected %0d, got %0d",
                   exp_res.took_foreground, grad_if.took_foreground);
            err_cnt++;
          end
          if (grad_if.end_of_frame !== exp_res.end_of_frame) begin
            $error("end_of_frame: expected %0d, got %0d",
                   exp_res.end_of_frame, grad_if.end_of_frame);
            err_cnt++;
          end
        end
      end
    end
  end

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) @(posedge clk_i) cycle_cnt++;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int          rand_items;
    int unsigned w, h;
    logic [WEIGHT_BITS-1:0] weight;
    rst_ni           = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    pix_if.valid     = 1'b0;
    pix_if.func      = FUNC_PIXEL;
    pix_if.fg_sample = '0;
    pix_if.bg_sample = '0;
    grad_if.ready    = 1'b0;
    err_cnt          = 0;
    cycle_cnt        = 0;
    idle_on          = 1'b1;
    hold_req         = 1'b0;
    in_gap           = 0;
    out_stall        = 0;
    cfg_width        = WIDTH_BITS'(WIDTH_RESET);
    cfg_height       = HEIGHT_BITS'(HEIGHT_RESET);
    cfg_mixed        = 1'b0;
    cfg_weight       = WEIGHT_BITS'(WEIGHT_ONE);
    clear_position();
    for (int i = 0; i < RING_DEPTH; i++) begin
      fg_ring[RING_ADDR_BITS'(i)] = '0;
      bg_ring[RING_ADDR_BITS'(i)] = '0;
    end
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // checkerboard extremes, early flush, pixel past the frame, flush with nothing pending
    configure(11'd3, 16'd3, 1'b0, WEIGHT_BITS'(WEIGHT_ONE));
    push_flush();
    for (int i = 0; i < 9; i++) begin
      push_pixel((i % 2 == 0) ? 8'd0 : 8'd255, (i % 2 == 0) ? 8'd255 : 8'd0);
      if (i == 3) push_flush();
    end
    push_pixel(8'd77, 8'd33);
    repeat (3) push_flush();
    push_flush();
    settle();

    // mixed pick with a tie going to the background
    configure(11'd2, 16'd2, 1'b1, WEIGHT_BITS'(WEIGHT_ONE));
    push_pixel(8'd5, 8'd9);
    push_pixel(8'd5, 8'd9);
    push_pixel(8'd5, 8'd9);
    push_pixel(8'd200, 8'd9);
    repeat (3) push_flush();
    settle();

    // zero width, weight above one
    configure(11'd0, 16'd3, 1'b0, 9'd511);
    push_pixel(8'd10, 8'd0);
    push_pixel(8'd250, 8'd255);
    push_pixel(8'd40, 8'd1);
    repeat (2) push_flush();
    settle();

    // tallest frame, cut short, with a long output hold
    configure(11'd1, 16'd65535, 1'b1, 9'd128);
    hold_req = 1'b1;
    repeat (40) begin
      push_pixel(SAMPLE_BITS'($urandom_range(0, 255)), SAMPLE_BITS'($urandom_range(0, 255)));
    end
    settle();

    // width above the line limit and zero height, cut short before the frame completes
    configure(11'd2047, 16'd0, 1'b0, 9'd0);
    repeat (40) begin
      push_pixel(SAMPLE_BITS'($urandom_range(0, 255)), SAMPLE_BITS'($urandom_range(0, 255)));
    end
    repeat (4) push_flush();
    settle();

    rand_items = 0;
    while (rand_items < RAND_ITEMS) begin
      if (rand_items > RAND_ITEMS - 100) idle_on = 1'b0;
      else idle_on = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 19))
        0:       w = 0;
        1:       w = 1;
        2:       w = $urandom_range(9, 40);
        default: w = $urandom_range(2, 8);
      endcase
      h = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 6);
      case ($urandom_range(0, 3))
        0:       weight = 9'd0;
        1:       weight = WEIGHT_BITS'(WEIGHT_ONE);
        2:       weight = WEIGHT_BITS'($urandom_range(WEIGHT_ONE + 1, 511));
        default: weight = WEIGHT_BITS'($urandom_range(0, WEIGHT_ONE));
      endcase
      configure(WIDTH_BITS'(w), HEIGHT_BITS'(h), 1'($urandom_range(0, 1)), weight);
      queue_frame(w, h, rand_items);
      if ($urandom_range(0, 4) == 0) queue_frame(w, h, rand_items);
      settle();
    end

    if (err_cnt == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
